>>> hdl/hld_pkg.sv
// Shared types, codes and constants of the heartbeat leader detector.
package hld_pkg;

  localparam int NODE_COUNT_DEF = 4;
  localparam int RING_DEPTH_DEF = 5;
  localparam int SCORE_MAX_DEF  = 15;

  localparam int BEAT_W  = 32;
  localparam int ADDR_W  = 48;
  localparam int QP_W    = 6;
  localparam int MASK_W  = 8;
  localparam int NODE_ID_W = 3;
  localparam int RING_W  = 4;
  localparam int TICK_W  = 16;
  localparam int THR_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

  localparam logic [NODE_ID_W-1:0] MY_NODE_ID_RST      = 3'd0;
  localparam logic [TICK_W-1:0]    SCAN_PERIOD_RST     = 16'd50;
  localparam logic [THR_W-1:0]     ALIVE_THRESHOLD_RST = 4'd6;
  localparam logic [THR_W-1:0]     DEAD_THRESHOLD_RST  = 4'd2;
  localparam logic [31:0]          BASE_ADDRESS_RST    = 32'h0000_0000;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_REPLY = 1'b1;

  typedef enum logic [1:0] {
    KIND_BEAT   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_LEADER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_BEAT = 2'd0,
    OP_SCAN = 2'd1,
    OP_LEAD = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MY_NODE_ID      = 3'd0,
    REG_SCAN_PERIOD     = 3'd1,
    REG_ALIVE_THRESHOLD = 3'd2,
    REG_DEAD_THRESHOLD  = 3'd3,
    REG_BASE_ADDRESS    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [NODE_ID_W-1:0] my_node_id;
    logic [TICK_W-1:0]    scan_period;
    logic [THR_W-1:0]     alive_threshold;
    logic [THR_W-1:0]     dead_threshold;
    logic [31:0]          base_address;
  } cfg_t;

  typedef struct packed {
    op_t                  op;
    logic [BEAT_W-1:0]    beat;
    logic [MASK_W-1:0]    mask_pre;
    logic [MASK_W-1:0]    mask_post;
    logic [NODE_ID_W-1:0] leader;
    logic [RING_W-1:0]    ring;
  } job_t;

endpackage

>>> hdl/hld_front.sv
// Front part: takes ticks and replies, keeps scanner and node state, queues jobs.
module hld_front #(
  parameter int NODE_COUNT = hld_pkg::NODE_COUNT_DEF,
  parameter int RING_DEPTH = hld_pkg::RING_DEPTH_DEF,
  parameter int SCORE_MAX  = hld_pkg::SCORE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hld_pkg::cfg_t        cfg,
  input  logic                 in_push,
  input  logic                 in_action,
  input  logic [2:0]           in_peer_slot,
  input  logic [31:0]          in_heartbeat_value,
  input  logic                 jq_full,
  output logic                 jq_push,
  output hld_pkg::job_t        jq_job
);
  import hld_pkg::*;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int SCORE_W = $clog2(SCORE_MAX + 1);
  localparam int CMP_W   = (SCORE_W > THR_W) ? SCORE_W : THR_W;

  typedef enum logic [1:0] {
    PH_SCAN  = 2'd0,
    PH_READ  = 2'd1,
    PH_ELECT = 2'd2
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [BEAT_W-1:0]       beat_r, beat_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [RING_W-1:0]       ring_r, ring_nxt;
  logic [BEAT_W-1:0]       newest_r [NODE_COUNT];
  logic [BEAT_W-1:0]       newest_nxt [NODE_COUNT];
  logic [BEAT_W-1:0]       prev_r [NODE_COUNT];
  logic [BEAT_W-1:0]       prev_nxt [NODE_COUNT];
  logic [SCORE_W-1:0]      score_r [NODE_COUNT];
  logic [SCORE_W-1:0]      score_nxt [NODE_COUNT];
  logic [NODE_COUNT-1:0]   alive_r, alive_nxt;
  logic [NODE_ID_W-1:0]    leader_r, leader_nxt;

  logic                    accept;
  logic                    self_in;
  logic [NODE_ID_W:0]      node;
  logic [TICK_W-1:0]       tick_inc;
  logic                    found;
  logic [NODE_ID_W-1:0]    lead;

  assign accept  = in_push && !jq_full;
  assign self_in = {1'b0, cfg.my_node_id} < (NODE_ID_W+1)'(NODE_COUNT);
  assign node    = (in_peer_slot < cfg.my_node_id) ? {1'b0, in_peer_slot}
                                                   : {1'b0, in_peer_slot} + 4'd1;
  assign tick_inc = tick_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    beat_nxt   = beat_r;
    tick_nxt   = tick_r;
    ring_nxt   = ring_r;
    newest_nxt = newest_r;
    prev_nxt   = prev_r;
    score_nxt  = score_r;
    alive_nxt  = alive_r;
    leader_nxt = leader_r;
    found      = 1'b0;
    lead       = leader_r;
    jq_push    = 1'b0;
    jq_job.op        = OP_BEAT;
    jq_job.beat      = beat_r + 32'd1;
    jq_job.mask_pre  = MASK_W'(alive_r);
    jq_job.mask_post = MASK_W'(alive_r);
    jq_job.leader    = leader_r;
    jq_job.ring      = ring_r;
    if (accept) begin
      if (in_action == ACT_REPLY) begin
        if (node < (NODE_ID_W+1)'(NODE_COUNT)) begin
          newest_nxt[node[NODE_W-1:0]] = in_heartbeat_value;
        end
      end else begin
        jq_push  = 1'b1;
        beat_nxt = beat_r + 32'd1;
        if (tick_inc == cfg.scan_period) begin
          tick_nxt = '0;
          case (phase_r)
            PH_SCAN: begin
              jq_job.op = OP_SCAN;
              ring_nxt  = (({1'b0, ring_r} + 5'd1) >= 5'(RING_DEPTH)) ? '0 : ring_r + 4'd1;
              phase_nxt = PH_READ;
            end
            PH_READ: begin
              for (int i = 0; i < NODE_COUNT; i++) begin
                if ((NODE_ID_W+1)'(i) != {1'b0, cfg.my_node_id}) begin
                  if (newest_r[i] > prev_r[i]) begin
                    if (score_r[i] < SCORE_W'(SCORE_MAX)) begin
                      score_nxt[i] = score_r[i] + SCORE_W'(1);
                    end
                  end else if (score_r[i] != '0) begin
                    score_nxt[i] = score_r[i] - SCORE_W'(1);
                  end
                  prev_nxt[i] = newest_r[i];
                end
              end
              phase_nxt = PH_ELECT;
            end
            PH_ELECT: begin
              for (int i = 0; i < NODE_COUNT; i++) begin
                if (CMP_W'(score_r[i]) >= CMP_W'(cfg.alive_threshold)) begin
                  alive_nxt[i] = 1'b1;
                end else if (CMP_W'(score_r[i]) < CMP_W'(cfg.dead_threshold)) begin
                  alive_nxt[i] = 1'b0;
                end
              end
              if (self_in) begin
                alive_nxt[cfg.my_node_id[NODE_W-1:0]] = 1'b1;
              end
              for (int i = NODE_COUNT - 1; i >= 0; i--) begin
                if (alive_nxt[i]) begin
                  lead  = NODE_ID_W'(i);
                  found = 1'b1;
                end
              end
              if (found && (lead != leader_r)) begin
                leader_nxt       = lead;
                jq_job.op        = OP_LEAD;
                jq_job.leader    = lead;
                jq_job.mask_post = MASK_W'(alive_nxt);
              end
              phase_nxt = PH_SCAN;
            end
            default: begin
              phase_nxt = PH_SCAN;
            end
          endcase
        end else begin
          tick_nxt = tick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SCAN;
      beat_r   <= '0;
      tick_r   <= '0;
      ring_r   <= '0;
      alive_r  <= '0;
      leader_r <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        newest_r[i] <= '0;
        prev_r[i]   <= '0;
        score_r[i]  <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      beat_r   <= beat_nxt;
      tick_r   <= tick_nxt;
      ring_r   <= ring_nxt;
      alive_r  <= alive_nxt;
      leader_r <= leader_nxt;
      newest_r <= newest_nxt;
      prev_r   <= prev_nxt;
      score_r  <= score_nxt;
    end
  end

endmodule

>>> hdl/hld_jobq.sv
// Job queue between the front and back parts.
module hld_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hld_pkg::job_t push_job,
  input  logic          pop,
  output hld_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import hld_pkg::*;

  job_t                  mem_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wp_r, wp_nxt;
  logic [JOBQ_PTR_W-1:0] rp_r, rp_nxt;
  logic [JOBQ_PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (JOBQ_PTR_W+1)'(JOBQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

>>> hdl/hld_back.sv
// Back part: expands each job into output register result items, one per unstalled cycle.
module hld_back #(
  parameter int NODE_COUNT = hld_pkg::NODE_COUNT_DEF,
  parameter int RING_DEPTH = hld_pkg::RING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hld_pkg::cfg_t        cfg,
  input  hld_pkg::job_t        job,
  input  logic                 jq_empty,
  output logic                 jq_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [1:0]           out_kind,
  output logic [5:0]           out_queue_pair,
  output logic [47:0]          out_local_address,
  output logic [31:0]          out_result_value,
  output logic [7:0]           out_alive_mask,
  output logic                 out_last
);
  import hld_pkg::*;

  localparam int STEP_W = $clog2(NODE_COUNT + 2);
  localparam int OFF_W  = $clog2(RING_DEPTH * NODE_COUNT + 1);

  logic                 out_valid_r, out_valid_nxt;
  kind_t                kind_r, kind_nxt;
  logic [QP_W-1:0]      qp_r, qp_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [BEAT_W-1:0]    val_r, val_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic                 last_r, last_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  logic                 taken;
  logic                 advance;
  logic [STEP_W-1:0]    npeer;
  logic [STEP_W-1:0]    last_step;
  logic                 is_last;
  logic [STEP_W-1:0]    peer;
  logic [OFF_W-1:0]     off;
  logic [QP_W-1:0]      qp_calc;

  assign taken   = out_pop && out_valid_r;
  assign advance = !jq_empty && (!out_valid_r || out_pop);
  assign npeer   = ({1'b0, cfg.my_node_id} < (NODE_ID_W+1)'(NODE_COUNT))
                   ? STEP_W'(NODE_COUNT - 1) : STEP_W'(NODE_COUNT);

  always_comb begin
    case (job.op)
      OP_SCAN: last_step = npeer;
      OP_LEAD: last_step = STEP_W'(1);
      default: last_step = '0;
    endcase
  end

  assign is_last = (step_r == last_step);
  assign jq_pop  = advance && is_last;
  assign peer    = step_r - STEP_W'(1);
  assign off     = OFF_W'(RING_DEPTH) * OFF_W'(peer) + OFF_W'(job.ring);
  assign qp_calc = QP_W'(NODE_COUNT - 1) * QP_W'(cfg.my_node_id) + QP_W'(peer);

  always_comb begin
    out_valid_nxt = taken ? 1'b0 : out_valid_r;
    step_nxt = step_r;
    kind_nxt = kind_r;
    qp_nxt   = qp_r;
    addr_nxt = addr_r;
    val_nxt  = val_r;
    mask_nxt = mask_r;
    last_nxt = last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      step_nxt = is_last ? '0 : step_r + STEP_W'(1);
      last_nxt = is_last;
      if (step_r == '0) begin
        kind_nxt = KIND_BEAT;
        qp_nxt   = '0;
        addr_nxt = ADDR_W'(cfg.base_address);
        val_nxt  = job.beat;
        mask_nxt = job.mask_pre;
      end else if (job.op == OP_SCAN) begin
        kind_nxt = KIND_READ;
        qp_nxt   = qp_calc;
        addr_nxt = ADDR_W'(cfg.base_address) + ADDR_W'(4) + (ADDR_W'(off) << 2);
        val_nxt  = '0;
        mask_nxt = job.mask_pre;
      end else begin
        kind_nxt = KIND_LEADER;
        qp_nxt   = '0;
        addr_nxt = '0;
        val_nxt  = BEAT_W'(job.leader);
        mask_nxt = job.mask_post;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    qp_r   <= qp_nxt;
    addr_r <= addr_nxt;
    val_r  <= val_nxt;
    mask_r <= mask_nxt;
    last_r <= last_nxt;
  end

  assign out_empty         = !out_valid_r;
  assign out_kind          = kind_r;
  assign out_queue_pair    = qp_r;
  assign out_local_address = addr_r;
  assign out_result_value  = val_r;
  assign out_alive_mask    = mask_r;
  assign out_last          = last_r;

endmodule

>>> hdl/heartbeat_leader_detector_top.sv
// Top level of the heartbeat leader detector: configuration registers and part wiring.
//
//   channel  handshake           transfer when        payload
//   in       in_push / in_full   push & !full         action, peer_slot, heartbeat_value
//   out      out_pop / out_empty pop & !empty         kind, queue_pair, local_address,
//                                                     result_value, alive_mask, last
//   cfg      cfg_valid/cfg_ready valid & ready        cfg_index, cfg_wdata
//
// The front takes one item per cycle while the four-entry job queue has room; replies
// finish in the front. A tick yields 1 result, NODE_COUNT or NODE_COUNT+1 on scan steps,
// or 2 on a leader change; the back sends one result per cycle while the out side pops.
// The first result of a tick passes through the job queue, then the output register.
// Reset (rst_n low, synchronous) loads register defaults and clears all state but job storage and output payload.
// A stalled out side fills the job queue, then in_full rises.
module heartbeat_leader_detector_top #(
  parameter int NODE_COUNT = hld_pkg::NODE_COUNT_DEF,
  parameter int RING_DEPTH = hld_pkg::RING_DEPTH_DEF,
  parameter int SCORE_MAX  = hld_pkg::SCORE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_action,
  input  logic [2:0]                     in_peer_slot,
  input  logic [31:0]                    in_heartbeat_value,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [1:0]                     out_kind,
  output logic [5:0]                     out_queue_pair,
  output logic [47:0]                    out_local_address,
  output logic [31:0]                    out_result_value,
  output logic [7:0]                     out_alive_mask,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hld_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hld_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic jq_push;
  logic jq_pop;
  logic jq_full;
  logic jq_empty;
  job_t jq_in;
  job_t jq_head;

  assign cfg_ready = 1'b1;
  assign in_full   = jq_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MY_NODE_ID:      cfg_nxt.my_node_id      = cfg_wdata[NODE_ID_W-1:0];
        REG_SCAN_PERIOD:     cfg_nxt.scan_period     = cfg_wdata[TICK_W-1:0];
        REG_ALIVE_THRESHOLD: cfg_nxt.alive_threshold = cfg_wdata[THR_W-1:0];
        REG_DEAD_THRESHOLD:  cfg_nxt.dead_threshold  = cfg_wdata[THR_W-1:0];
        REG_BASE_ADDRESS:    cfg_nxt.base_address    = cfg_wdata[31:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_node_id      <= MY_NODE_ID_RST;
      cfg_r.scan_period     <= SCAN_PERIOD_RST;
      cfg_r.alive_threshold <= ALIVE_THRESHOLD_RST;
      cfg_r.dead_threshold  <= DEAD_THRESHOLD_RST;
      cfg_r.base_address    <= BASE_ADDRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hld_front #(
    .NODE_COUNT (NODE_COUNT),
    .RING_DEPTH (RING_DEPTH),
    .SCORE_MAX  (SCORE_MAX)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_push            (in_push),
    .in_action          (in_action),
    .in_peer_slot       (in_peer_slot),
    .in_heartbeat_value (in_heartbeat_value),
    .jq_full            (jq_full),
    .jq_push            (jq_push),
    .jq_job             (jq_in)
  );

  hld_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_in),
    .pop      (jq_pop),
    .head     (jq_head),
    .full     (jq_full),
    .empty    (jq_empty)
  );

  hld_back #(
    .NODE_COUNT (NODE_COUNT),
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .job               (jq_head),
    .jq_empty          (jq_empty),
    .jq_pop            (jq_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_kind          (out_kind),
    .out_queue_pair    (out_queue_pair),
    .out_local_address (out_local_address),
    .out_result_value  (out_result_value),
    .out_alive_mask    (out_alive_mask),
    .out_last          (out_last)
  );

endmodule
